@@ src/whmd_pkg.sv @@
// ----------------------------------------------------------------------------
// whmd_pkg
// Shared constants and types of the windowed hit/miss density cell.
// ----------------------------------------------------------------------------
package whmd_pkg;

	localparam int FIFO_DEPTH   = 64;
	localparam int PTR_W        = $clog2(FIFO_DEPTH);
	localparam int CNT_W        = PTR_W + 1;
	localparam int TIME_WIDTH   = 32;
	localparam int DENSITY_FRAC = 12;

	localparam logic [16:0] ONE_Q16  = 17'd65536;
	localparam logic [31:0] K196     = 32'd128451;
	localparam logic [31:0] K096     = 32'd62915;
	localparam logic [31:0] LN2_Q28  = 32'd186065279;
	localparam int          SCALE_SH = 46 - DENSITY_FRAC;
	localparam logic [63:0] DENS_MAX = 64'd2147483647;

	// Configuration seen by the density unit
	typedef struct packed {
		logic [23:0]        inv_area;
		logic [16:0]        miss_prob;
		logic [16:0]        hit_prob;
		logic [30:0]        ceiling;
		logic signed [31:0] unmeasured;
		logic [7:0]         min_measures;
	} whmd_cfg_t;

	// Density results of one request
	typedef struct packed {
		logic signed [31:0] density;
		logic signed [31:0] upper;
		logic signed [31:0] lower;
	} whmd_res_t;

endpackage

@@ src/whmd_dens.sv @@
// ----------------------------------------------------------------------------
// whmd_dens
// Sequenced density unit: mean and variance, integer square root, and three
// log-ratio densities, all on one registered 32x32 multiplier.
// ----------------------------------------------------------------------------
module whmd_dens import whmd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  whmd_cfg_t        cfg,
	input  logic [CNT_W-1:0] h,
	input  logic [CNT_W-1:0] m,
	output logic             done,
	output whmd_res_t        res
);

	localparam int MU_W   = 24;
	localparam int SIG_W  = 38;
	localparam int NUM_W  = 24;
	localparam int REM_W  = NUM_W + 30;
	localparam int TERM_W = 22;

	typedef enum logic [4:0] {
		D_IDLE, D_P0, D_P1, D_P2, D_P3, D_P4, D_P5, D_P6, D_SQRT,
		D_T0, D_T1, D_T2, D_JOB, D_LK, D_LDIV, D_LSQA, D_LSQB,
		D_LM0, D_LM1, D_LM2, D_LM3, D_LM4, D_LM5
	} dstate_t;

	typedef enum logic [1:0] {JOB_DENS, JOB_UP, JOB_LOW} job_t;

	dstate_t            state_q;
	job_t               job_q;
	logic [30:0]        vh_q, vm_q;
	logic [SIG_W-1:0]   sig2_q, sq_v_q, sq_res_q, sq_bit_q;
	logic [MU_W-1:0]    mu_q;
	logic [TERM_W-1:0]  termu_q, terml_q;
	logic [NUM_W-1:0]   num_q, den_q;
	logic [4:0]         k_q, it_q;
	logic [REM_W-1:0]   rem_q, dsh_q;
	logic [31:0]        y_q;
	logic [29:0]        frac_q;
	logic [63:0]        acc_q, p_q;
	logic [35:0]        ln_q;
	logic               done_q;
	logic signed [31:0] dens_q, up_q, low_q;

	// shared multiplier
	logic [31:0] ma, mb;
	logic [63:0] prod;
	logic [16:0] ph_c, pm_c;

	assign ph_c = ONE_Q16 - cfg.hit_prob;
	assign pm_c = ONE_Q16 - cfg.miss_prob;

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			D_P0: begin ma = 32'(cfg.hit_prob); mb = 32'(ph_c); end
			D_P1: begin ma = 32'(cfg.miss_prob); mb = 32'(pm_c); end
			D_P2: begin ma = 32'(h); mb = 32'(vh_q); end
			D_P3: begin ma = 32'(m); mb = 32'(vm_q); end
			D_P4: begin ma = 32'(h); mb = 32'(cfg.hit_prob); end
			D_P5: begin ma = 32'(m); mb = 32'(pm_c); end
			D_T0: begin ma = K196; mb = sq_res_q[31:0]; end
			D_T1: begin ma = K096; mb = sq_res_q[31:0]; end
			D_LSQA: begin ma = y_q; mb = y_q; end
			D_LM0: begin ma = 32'(frac_q); mb = LN2_Q28; end
			D_LM1: begin ma = 32'(k_q); mb = LN2_Q28; end
			D_LM3: begin ma = 32'(cfg.inv_area); mb = ln_q[31:0]; end
			D_LM4: begin ma = 32'(cfg.inv_area); mb = 32'(ln_q[35:32]); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign prod = ma * mb;

	always_ff @(posedge clk) begin
		p_q <= prod;
	end

	// per-job operand selection and special cases
	logic [7:0]         n;
	logic [NUM_W-1:0]   n16;
	logic [NUM_W:0]     kb_up;
	logic [NUM_W-1:0]   kb_lo;
	logic               spec;
	logic [31:0]        spec_val;
	logic [NUM_W-1:0]   job_num, job_den;
	logic [31:0]        ceil32;

	assign n      = {1'b0, h} + {1'b0, m};
	assign n16    = {n, 16'b0};
	assign kb_up  = {1'b0, mu_q} + {3'b0, termu_q};
	assign kb_lo  = mu_q - {2'b0, terml_q};
	assign ceil32 = {1'b0, cfg.ceiling};

	always_comb begin
		spec     = 1'b0;
		spec_val = '0;
		job_num  = n16;
		job_den  = '0;
		case (job_q)
			JOB_DENS: begin
				job_num = {16'b0, n};
				job_den = {17'b0, m};
				if (n < cfg.min_measures) begin
					spec = 1'b1; spec_val = cfg.unmeasured;
				end else if (m == '0) begin
					spec = 1'b1; spec_val = ceil32;
				end
			end
			JOB_UP: begin
				job_den = n16 - kb_up[NUM_W-1:0];
				if (kb_up >= {1'b0, n16}) begin
					spec = 1'b1; spec_val = ceil32;
				end
			end
			default: begin
				job_den = n16 - kb_lo;
				if (n == '0) begin
					spec = 1'b1; spec_val = cfg.unmeasured;
				end else if ({2'b0, terml_q} >= mu_q) begin
					spec = 1'b1; spec_val = '0;
				end else if (kb_lo >= n16) begin
					spec = 1'b1; spec_val = ceil32;
				end
			end
		endcase
		// ratio not above one gives a zero log
		if (!spec && job_num <= job_den) begin
			spec = 1'b1; spec_val = '0;
		end
	end

	// datapath helpers
	logic [SIG_W:0]   sq_sum;
	logic             sq_ge;
	logic [NUM_W+30:0] lk_rhs;
	logic             lk_ge;
	logic [31:0]      sq_t;
	logic [63:0]      ln_sum, sc_tot, sc_rnd, sc_sh;
	logic [31:0]      sc_val;
	logic             store_en;
	logic [31:0]      store_val;

	assign sq_sum = {1'b0, sq_res_q} + {1'b0, sq_bit_q};
	assign sq_ge  = {1'b0, sq_v_q} >= sq_sum;
	assign lk_rhs = {31'b0, den_q} << ({1'b0, k_q} + 6'd1);
	assign lk_ge  = {31'b0, num_q} >= lk_rhs;
	assign sq_t   = p_q[61:30];
	assign ln_sum = acc_q + {p_q[33:0], 30'b0};
	assign sc_tot = acc_q + {p_q[31:0], 32'b0};
	assign sc_rnd = sc_tot + (64'd1 << (SCALE_SH - 1));
	assign sc_sh  = sc_rnd >> SCALE_SH;
	assign sc_val = (sc_sh > DENS_MAX) ? DENS_MAX[31:0] : sc_sh[31:0];

	assign store_en  = (state_q == D_JOB && spec) || state_q == D_LM5;
	assign store_val = (state_q == D_LM5) ? sc_val : spec_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			job_q   <= JOB_DENS;
		end else begin
			done_q <= store_en && (job_q == JOB_LOW);
			if (store_en) begin
				case (job_q)
					JOB_DENS: dens_q <= store_val;
					JOB_UP:   up_q   <= store_val;
					default:  low_q  <= store_val;
				endcase
				if (job_q == JOB_LOW) begin
					state_q <= D_IDLE;
				end else begin
					job_q   <= (job_q == JOB_DENS) ? JOB_UP : JOB_LOW;
					state_q <= D_JOB;
				end
			end else begin
				unique case (state_q)
					D_IDLE: if (start) state_q <= D_P0;
					D_P0: state_q <= D_P1;
					D_P1: begin vh_q <= p_q[30:0]; state_q <= D_P2; end
					D_P2: begin vm_q <= p_q[30:0]; state_q <= D_P3; end
					D_P3: begin sig2_q <= p_q[SIG_W-1:0]; state_q <= D_P4; end
					D_P4: begin sig2_q <= sig2_q + p_q[SIG_W-1:0]; state_q <= D_P5; end
					D_P5: begin mu_q <= p_q[MU_W-1:0]; state_q <= D_P6; end
					D_P6: begin
						mu_q     <= mu_q + p_q[MU_W-1:0];
						sq_v_q   <= sig2_q;
						sq_res_q <= '0;
						sq_bit_q <= SIG_W'(1) << (SIG_W - 2);
						state_q  <= D_SQRT;
					end
					D_SQRT: begin
						if (sq_ge) begin
							sq_v_q   <= sq_v_q - sq_sum[SIG_W-1:0];
							sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
						end else begin
							sq_res_q <= sq_res_q >> 1;
						end
						sq_bit_q <= sq_bit_q >> 2;
						if (sq_bit_q == SIG_W'(1)) state_q <= D_T0;
					end
					D_T0: state_q <= D_T1;
					D_T1: begin
						termu_q <= TERM_W'((p_q + 64'd32768) >> 16);
						state_q <= D_T2;
					end
					D_T2: begin
						terml_q <= TERM_W'((p_q + 64'd32768) >> 16);
						job_q   <= JOB_DENS;
						state_q <= D_JOB;
					end
					D_JOB: begin
						num_q   <= job_num;
						den_q   <= job_den;
						k_q     <= '0;
						state_q <= D_LK;
					end
					D_LK: begin
						if (k_q != 5'd30 && lk_ge) begin
							k_q <= k_q + 5'd1;
						end else begin
							rem_q   <= {num_q, 30'b0};
							dsh_q   <= REM_W'({den_q, 30'b0} << k_q);
							y_q     <= '0;
							it_q    <= '0;
							state_q <= D_LDIV;
						end
					end
					D_LDIV: begin
						if (rem_q >= dsh_q) begin
							rem_q <= rem_q - dsh_q;
							y_q   <= {y_q[30:0], 1'b1};
						end else begin
							y_q   <= {y_q[30:0], 1'b0};
						end
						dsh_q <= dsh_q >> 1;
						if (it_q == 5'd30) begin
							it_q    <= '0;
							frac_q  <= '0;
							state_q <= D_LSQA;
						end else begin
							it_q <= it_q + 5'd1;
						end
					end
					D_LSQA: state_q <= D_LSQB;
					D_LSQB: begin
						if (sq_t[31]) begin
							y_q    <= sq_t >> 1;
							frac_q <= {frac_q[28:0], 1'b1};
						end else begin
							y_q    <= sq_t;
							frac_q <= {frac_q[28:0], 1'b0};
						end
						it_q    <= it_q + 5'd1;
						state_q <= (it_q == 5'd29) ? D_LM0 : D_LSQA;
					end
					D_LM0: state_q <= D_LM1;
					D_LM1: begin acc_q <= p_q; state_q <= D_LM2; end
					D_LM2: begin
						ln_q    <= 36'((ln_sum + (64'd1 << 27)) >> 28);
						state_q <= D_LM3;
					end
					D_LM3: state_q <= D_LM4;
					D_LM4: begin acc_q <= p_q; state_q <= D_LM5; end
					default: state_q <= D_IDLE;
				endcase
			end
		end
	end

	assign done        = done_q;
	assign res.density = dens_q;
	assign res.upper   = up_q;
	assign res.lower   = low_q;

endmodule

@@ src/windowed_hit_miss_density_cell_unit.sv @@
// ----------------------------------------------------------------------------
// windowed_hit_miss_density_cell_unit
// One lidar grid cell: windowed hit/miss time FIFOs and density estimates.
// ----------------------------------------------------------------------------
// Each request either pushes a hit or miss time stamp into its 64-entry FIFO,
// expires old entries from both FIFOs at a given current time, or (kind 3)
// only reports. Every request returns one result with both counts and the
// lambda estimate plus its upper and lower confidence bounds in signed Q19.12.
// The block takes one request at a time; in_ready is high only while idle, but
// a new request is taken while the previous result still waits on the output
// register. A push writes its stamp into its FIFO; expiry spends a memory read
// and an age check on each FIFO entry examined, and the density sequencer
// then works through mean, variance and a 19-step square root, followed by up
// to three log ratios (normalize, 31-step divide, 30 squarings on the one
// shared 32x32 multiplier, scaling). Special cases skip their log ratio.
// Configuration is to be written over the APB port only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module windowed_hit_miss_density_cell_unit import whmd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            kind,
	input  logic [TIME_WIDTH-1:0] time_stamp,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CNT_W-1:0]      hit_count,
	output logic [CNT_W-1:0]      miss_count,
	output logic signed [31:0]    density,
	output logic signed [31:0]    density_upper,
	output logic signed [31:0]    density_lower,
	output logic                  overflow,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [4:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam logic [1:0] KIND_HIT    = 2'd0;
	localparam logic [1:0] KIND_MISS   = 2'd1;
	localparam logic [1:0] KIND_EXPIRE = 2'd2;

	typedef enum logic [2:0] {
		REG_INV_AREA, REG_MISS_PROB, REG_HIT_PROB, REG_CEILING,
		REG_UNMEASURED, REG_MIN_MEASURES, REG_WINDOW
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_PUSH, S_EXP_HR, S_EXP_HC, S_EXP_MR, S_EXP_MC,
		S_START, S_WAIT, S_PUBLISH
	} state_t;

	function automatic logic [16:0] clamp_prob(input logic [16:0] v);
		clamp_prob = (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [23:0]        inv_area_q;
	logic [16:0]        miss_prob_q, hit_prob_q;
	logic [30:0]        ceiling_q;
	logic signed [31:0] unmeasured_q;
	logic [7:0]         min_measures_q;
	logic [31:0]        window_q;
	logic               cfg_wr;
	reg_idx_t           reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_area_q     <= 24'd65536;
			miss_prob_q    <= ONE_Q16;
			hit_prob_q     <= ONE_Q16;
			ceiling_q      <= 31'd409600000;
			unmeasured_q   <= -32'sd4096;
			min_measures_q <= 8'd1;
			window_q       <= 32'd1000;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_INV_AREA:     inv_area_q     <= pwdata[23:0];
				REG_MISS_PROB:    miss_prob_q    <= clamp_prob(pwdata[16:0]);
				REG_HIT_PROB:     hit_prob_q     <= clamp_prob(pwdata[16:0]);
				REG_CEILING:      ceiling_q      <= pwdata[30:0];
				REG_UNMEASURED:   unmeasured_q   <= pwdata;
				REG_MIN_MEASURES: min_measures_q <= pwdata[7:0];
				REG_WINDOW:       window_q       <= pwdata;
				default: ;  // unmapped slot: drop the write
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_INV_AREA:     prdata = 32'(inv_area_q);
			REG_MISS_PROB:    prdata = 32'(miss_prob_q);
			REG_HIT_PROB:     prdata = 32'(hit_prob_q);
			REG_CEILING:      prdata = 32'(ceiling_q);
			REG_UNMEASURED:   prdata = unmeasured_q;
			REG_MIN_MEASURES: prdata = 32'(min_measures_q);
			REG_WINDOW:       prdata = window_q;
			default:          prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Time FIFOs: circular memories with oldest pointer and fill count.
	// Entries are only ever read below the fill count, so no clearing.
	// ------------------------------------------------------------------
	logic [TIME_WIDTH-1:0] hit_mem  [FIFO_DEPTH];
	logic [TIME_WIDTH-1:0] miss_mem [FIFO_DEPTH];
	logic [TIME_WIDTH-1:0] hit_rd_q, miss_rd_q;
	logic [PTR_W-1:0]      hit_oldest_q, miss_oldest_q;
	logic [CNT_W-1:0]      hit_held_q, miss_held_q;
	logic [PTR_W-1:0]      hit_wr_addr, miss_wr_addr;
	logic                  hit_full, miss_full;

	state_t                state_q;
	logic [1:0]            kind_q;
	logic [TIME_WIDTH-1:0] now_q;
	logic                  ovf_q;

	assign hit_wr_addr  = hit_oldest_q + hit_held_q[PTR_W-1:0];
	assign miss_wr_addr = miss_oldest_q + miss_held_q[PTR_W-1:0];
	assign hit_full     = hit_held_q[PTR_W];
	assign miss_full    = miss_held_q[PTR_W];

	// Write on a push that fits; read the oldest entry every cycle.
	always_ff @(posedge clk) begin
		if (state_q == S_PUSH && kind_q == KIND_HIT && !hit_full)
			hit_mem[hit_wr_addr] <= now_q;
		if (state_q == S_PUSH && kind_q == KIND_MISS && !miss_full)
			miss_mem[miss_wr_addr] <= now_q;
		hit_rd_q  <= hit_mem[hit_oldest_q];
		miss_rd_q <= miss_mem[miss_oldest_q];
	end

	// An entry expires only when strictly older and past the window.
	logic hit_old, miss_old;
	assign hit_old  = (now_q > hit_rd_q) && ((now_q - hit_rd_q) > window_q);
	assign miss_old = (now_q > miss_rd_q) && ((now_q - miss_rd_q) > window_q);

	// ------------------------------------------------------------------
	// Density unit
	// ------------------------------------------------------------------
	whmd_cfg_t dens_cfg;
	whmd_res_t dens_res;
	logic      dens_start, dens_done;

	assign dens_cfg.inv_area     = inv_area_q;
	assign dens_cfg.miss_prob    = miss_prob_q;
	assign dens_cfg.hit_prob     = hit_prob_q;
	assign dens_cfg.ceiling      = ceiling_q;
	assign dens_cfg.unmeasured   = unmeasured_q;
	assign dens_cfg.min_measures = min_measures_q;
	assign dens_start            = (state_q == S_START);

	whmd_dens u_dens (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dens_start),
		.cfg    (dens_cfg),
		.h      (hit_held_q),
		.m      (miss_held_q),
		.done   (dens_done),
		.res    (dens_res)
	);

	// ------------------------------------------------------------------
	// Sequencer and output register
	// ------------------------------------------------------------------
	logic out_valid_q;
	logic publish;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	// advance only when the output register is free
	assign publish   = (state_q == S_PUBLISH) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			kind_q        <= KIND_HIT;
			now_q         <= '0;
			ovf_q         <= 1'b0;
			hit_oldest_q  <= '0;
			miss_oldest_q <= '0;
			hit_held_q    <= '0;
			miss_held_q   <= '0;
			out_valid_q   <= 1'b0;
			hit_count     <= '0;
			miss_count    <= '0;
			density       <= '0;
			density_upper <= '0;
			density_lower <= '0;
			overflow      <= 1'b0;
		end else begin
			// load a new result, else drop the old one once taken
			if (publish)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q <= kind;
						now_q  <= time_stamp;
						ovf_q  <= 1'b0;
						case (kind)
							KIND_HIT, KIND_MISS: state_q <= S_PUSH;
							KIND_EXPIRE:         state_q <= S_EXP_HR;
							default:             state_q <= S_START;
						endcase
					end
				end
				S_PUSH: begin
					// a push into a full FIFO is dropped and flagged
					if (kind_q == KIND_HIT) begin
						if (hit_full) ovf_q <= 1'b1;
						else          hit_held_q <= hit_held_q + CNT_W'(1);
					end else begin
						if (miss_full) ovf_q <= 1'b1;
						else           miss_held_q <= miss_held_q + CNT_W'(1);
					end
					state_q <= S_START;
				end
				// pause here so the registered read of the oldest entry settles
				S_EXP_HR: state_q <= (hit_held_q == '0) ? S_EXP_MR : S_EXP_HC;
				S_EXP_HC: begin
					if (hit_old) begin
						hit_oldest_q <= hit_oldest_q + PTR_W'(1);
						hit_held_q   <= hit_held_q - CNT_W'(1);
						state_q      <= S_EXP_HR;
					end else begin
						state_q <= S_EXP_MR;
					end
				end
				S_EXP_MR: state_q <= (miss_held_q == '0) ? S_START : S_EXP_MC;
				S_EXP_MC: begin
					if (miss_old) begin
						miss_oldest_q <= miss_oldest_q + PTR_W'(1);
						miss_held_q   <= miss_held_q - CNT_W'(1);
						state_q       <= S_EXP_MR;
					end else begin
						state_q <= S_START;
					end
				end
				S_START: state_q <= S_WAIT;
				S_WAIT:  if (dens_done) state_q <= S_PUBLISH;
				S_PUBLISH: begin
					if (publish) begin
						hit_count     <= hit_held_q;
						miss_count    <= miss_held_q;
						density       <= dens_res.density;
						density_upper <= dens_res.upper;
						density_lower <= dens_res.lower;
						overflow      <= ovf_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_hit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hit_held_q <= CNT_W'(FIFO_DEPTH))
		else $error("hit FIFO count beyond depth");

	a_miss_bound: assert property (@(posedge clk) disable iff (!arst_n)
		miss_held_q <= CNT_W'(FIFO_DEPTH))
		else $error("miss FIFO count beyond depth");

	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dens_done |-> state_q == S_WAIT)
		else $error("density done outside wait");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |->
			(hit_count == CNT_W'(FIFO_DEPTH) || miss_count == CNT_W'(FIFO_DEPTH)))
		else $error("overflow reported with room left");

endmodule
